### src/tlbtr_pkg.sv
// ----------------------------------------------------------------------------
// tlbtr_pkg
// Shared types and constants for the TLB and page table translator.
// ----------------------------------------------------------------------------
package tlbtr_pkg;

  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Widths of the address input and the reported result fields
  localparam int unsigned VA_W   = 16;
  localparam int unsigned PNUM_W = 8;
  localparam int unsigned OFF_W  = 8;
  localparam int unsigned FNUM_W = 8;
  localparam int unsigned PA_W   = 16;

  typedef enum logic [3:0] {
    ST_CLEAR   = 4'b0001,
    ST_IDLE    = 4'b0010,
    ST_LOOK    = 4'b0100,
    ST_RESOLVE = 4'b1000
  } tlbtr_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### src/tlbtr_cell.sv
// ----------------------------------------------------------------------------
// tlbtr_cell
// One TLB entry. Entries form a shift chain: on insert every cell takes its
// neighbor's entry, so the last cell always holds the oldest mapping.
// ----------------------------------------------------------------------------
module tlbtr_cell #(
  parameter int unsigned PW = 8,
  parameter int unsigned FW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic [PW-1:0] page_i,
  input  logic [FW-1:0] frame_i,
  input  logic          valid_i,
  input  logic [PW-1:0] look_page_i,
  output logic [PW-1:0] page_o,
  output logic [FW-1:0] frame_o,
  output logic          valid_o,
  output logic          match_o,
  output logic [FW-1:0] match_frame_o
);

  logic [PW-1:0] page_q;
  logic [FW-1:0] frame_q;
  logic          valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      page_q  <= page_i;
      frame_q <= frame_i;
    end
  end

  assign page_o        = page_q;
  assign frame_o       = frame_q;
  assign valid_o       = valid_q;
  assign match_o       = valid_q && (page_q == look_page_i);
  assign match_frame_o = match_o ? frame_q : '0;

endmodule

### src/tlbtr_table.sv
// ----------------------------------------------------------------------------
// tlbtr_table
// Page table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tlbtr_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 9
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical address translation through a FIFO-replaced TLB and a
// page table, allocating frames in order on page faults.
// ----------------------------------------------------------------------------
//  channel   | valid      | stall        | payload
//  ----------+------------+--------------+----------------------------------
//  input     | in_valid_i | in_stall_o   | virtual_address_i
//  output    | out_valid_o| out_stall_i  | page_number_o .. hit_total_o
//
// An address passes through capture (page quotient estimate), page table
// read, then TLB compare and update. A new address is taken the cycle after
// the update, so addresses never overlap; the quotient stage and the
// registered page table read set this. After reset a clearing pass walks
// the page table before the first transfer is taken.
// A stalled result holds the update step until the output register frees.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
  import tlbtr_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [VA_W-1:0]   virtual_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PNUM_W-1:0] page_number_o,
  output logic [OFF_W-1:0]  page_offset_o,
  output logic [FNUM_W-1:0] mapped_frame_o,
  output logic [PA_W-1:0]   physical_address_o,
  output logic              tlb_hit_o,
  output logic              page_fault_o,
  output logic              no_frame_o,
  output logic [CNT_W-1:0]  reference_total_o,
  output logic [CNT_W-1:0]  fault_total_o,
  output logic [CNT_W-1:0]  hit_total_o
);

  localparam int unsigned PW  = $clog2(PAGE_COUNT);
  localparam int unsigned FW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned NFW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned EW  = FW + 1;
  localparam logic [31:0] RECIP    = 32'((64'd1 << 32) / PAGE_COUNT);
  localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

  tlbtr_state_e state_q, state_d;

  logic [PW-1:0]   clr_q;
  logic [VA_W-1:0] va_q;
  logic [15:0]     quo_q;
  logic [PW-1:0]   page_q;
  logic [NFW-1:0]  nff_q;
  logic [CNT_W-1:0] ref_cnt_q, fault_cnt_q, hit_cnt_q;

  logic              out_valid_q;
  logic [PNUM_W-1:0] pnum_q;
  logic [OFF_W-1:0]  off_q;
  logic [FNUM_W-1:0] fnum_q;
  logic [PA_W-1:0]   pa_q;
  logic              hit_q, fault_q, none_q;

  // Page index = (va >> OFFSET_BITS) mod PAGE_COUNT via reciprocal estimate
  logic [15:0] page_raw_in, page_raw_q, rem, rem_fix;
  logic [47:0] prod;
  logic [31:0] qp;
  logic [PW-1:0] page_d;

  assign page_raw_in = VA_W'(virtual_address_i >> OFFSET_BITS);
  assign page_raw_q  = VA_W'(va_q >> OFFSET_BITS);
  assign prod        = 48'(page_raw_in) * 48'(RECIP);
  assign qp          = 32'(quo_q) * 32'(PAGE_COUNT);
  assign rem         = page_raw_q - qp[15:0];
  assign rem_fix     = (rem >= 16'(PAGE_COUNT)) ? rem - 16'(PAGE_COUNT) : rem;
  assign page_d      = rem_fix[PW-1:0];

  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_free = !out_valid_q || !out_stall_i;

  // TLB cell chain
  logic [PW-1:0] ch_page  [TLB_ENTRIES+1];
  logic [FW-1:0] ch_frame [TLB_ENTRIES+1];
  logic          ch_valid [TLB_ENTRIES+1];
  logic          cell_match [TLB_ENTRIES];
  logic [FW-1:0] cell_frame [TLB_ENTRIES];
  logic          tlb_shift;
  logic [FW-1:0] ins_frame;

  assign ch_page[0]  = page_q;
  assign ch_frame[0] = ins_frame;
  assign ch_valid[0] = 1'b1;

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    tlbtr_cell #(.PW(PW), .FW(FW)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .shift_i       (tlb_shift),
      .page_i        (ch_page[g]),
      .frame_i       (ch_frame[g]),
      .valid_i       (ch_valid[g]),
      .look_page_i   (page_q),
      .page_o        (ch_page[g+1]),
      .frame_o       (ch_frame[g+1]),
      .valid_o       (ch_valid[g+1]),
      .match_o       (cell_match[g]),
      .match_frame_o (cell_frame[g])
    );
  end

  // At most one entry holds a given page, so an OR of masked frames selects it
  logic          tlb_any;
  logic [FW-1:0] tlb_frame;
  always_comb begin
    tlb_any   = 1'b0;
    tlb_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_any   = tlb_any | cell_match[i];
      tlb_frame = tlb_frame | cell_frame[i];
    end
  end

  // Page table
  logic          tbl_wr_en, tbl_rd_en;
  logic [PW-1:0] tbl_wr_addr;
  logic [EW-1:0] tbl_wr_data, tbl_rd_data;

  tlbtr_table #(.DEPTH(PAGE_COUNT), .AW(PW), .DW(EW)) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (page_d),
    .rd_data_o (tbl_rd_data)
  );

  wire tbl_valid   = tbl_rd_data[EW-1];
  wire frame_avail = nff_q < NFW'(FRAME_COUNT);
  wire commit      = (state_q == ST_RESOLVE) && out_free;

  logic          do_hit, do_fault, do_none;
  logic [FW-1:0] res_frame;

  always_comb begin
    do_hit    = 1'b0;
    do_fault  = 1'b0;
    do_none   = 1'b0;
    tlb_shift = 1'b0;
    res_frame = '0;
    if (tlb_any) begin
      do_hit    = 1'b1;
      res_frame = tlb_frame;
    end else if (tbl_valid) begin
      res_frame = tbl_rd_data[FW-1:0];
      tlb_shift = commit;
    end else if (frame_avail) begin
      do_fault  = 1'b1;
      res_frame = nff_q[FW-1:0];
      tlb_shift = commit;
    end else begin
      do_none = 1'b1;
    end
  end

  assign ins_frame = res_frame;
  assign tbl_rd_en = (state_q == ST_LOOK);

  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = page_q;
    tbl_wr_data = {1'b1, res_frame};
    if (state_q == ST_CLEAR) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = clr_q;
      tbl_wr_data = '0;
    end else if (commit && do_fault) begin
      tbl_wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == PW'(PAGE_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      nff_q       <= '0;
      ref_cnt_q   <= '0;
      fault_cnt_q <= '0;
      hit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + PW'(1);
      if (commit) begin
        ref_cnt_q <= sat_inc(ref_cnt_q);
        if (do_hit)   hit_cnt_q   <= sat_inc(hit_cnt_q);
        if (do_fault) begin
          fault_cnt_q <= sat_inc(fault_cnt_q);
          nff_q       <= nff_q + NFW'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [31:0] frame32, off32, pa32, page32;
  assign frame32 = 32'(res_frame);
  assign off32   = 32'(va_q) & OFF_MASK;
  assign pa32    = (frame32 << OFFSET_BITS) | off32;
  assign page32  = 32'(page_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      va_q  <= virtual_address_i;
      quo_q <= prod[47:32];
    end
    if (state_q == ST_LOOK) page_q <= page_d;
    if (commit) begin
      pnum_q  <= page32[PNUM_W-1:0];
      off_q   <= off32[OFF_W-1:0];
      fnum_q  <= frame32[FNUM_W-1:0];
      pa_q    <= pa32[PA_W-1:0];
      hit_q   <= do_hit;
      fault_q <= do_fault;
      none_q  <= do_none;
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign page_number_o      = pnum_q;
  assign page_offset_o      = off_q;
  assign mapped_frame_o     = fnum_q;
  assign physical_address_o = pa_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign no_frame_o         = none_q;
  assign reference_total_o  = ref_cnt_q;
  assign fault_total_o      = fault_cnt_q;
  assign hit_total_o        = hit_cnt_q;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TLB and page table translator. A scoreboard
// class keeps its own TLB, page table and frame allocator, predicts every
// translation from the accepted address stream and checks each result.
// Directed addresses hit the field extremes, TLB hits, FIFO eviction and
// page-table-only hits; random traffic mixes a hot working set, uniform
// addresses and a page sweep, and a final full sweep uses up every frame.
// ----------------------------------------------------------------------------
module tb
  import tlbtr_pkg::*;
();

  localparam int unsigned TLB_N     = 16;
  localparam int unsigned PAGE_N    = 256;
  localparam int unsigned FRAME_N   = 256;
  localparam int unsigned OFS_BITS  = 8;
  localparam int unsigned RAND_N    = 520;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned DRAIN     = 20;
  localparam int unsigned LIMIT     = 200000;

  typedef struct {
    logic [PNUM_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic [FNUM_W-1:0] frame;
    logic [PA_W-1:0]   paddr;
    logic              hit;
    logic              fault;
    logic              no_frame;
    logic [CNT_W-1:0]  refs;
    logic [CNT_W-1:0]  faults;
    logic [CNT_W-1:0]  hits;
  } xlat_t;

  class xlat_board;
    bit [7:0]       tlb_pg[TLB_N];
    bit [7:0]       tlb_fr[TLB_N];
    bit             tlb_ok[TLB_N];
    bit [3:0]       fifo_slot;
    bit [7:0]       pt_frame[PAGE_N];
    bit             pt_ok[PAGE_N];
    bit [8:0]       free_frame;
    bit [CNT_W-1:0] ref_cnt, fault_cnt, hit_cnt;
    xlat_t          pending_xlats[$];
    int             fails;

    function new();
      for (int i = 0; i < TLB_N; i++) begin
        tlb_pg[i] = '0;
        tlb_fr[i] = '0;
        tlb_ok[i] = 1'b0;
      end
      for (int p = 0; p < PAGE_N; p++) begin
        pt_frame[p] = '0;
        pt_ok[p]    = 1'b0;
      end
      fifo_slot  = '0;
      free_frame = '0;
      ref_cnt    = '0;
      fault_cnt  = '0;
      hit_cnt    = '0;
      fails      = 0;
    endfunction

    function void tlb_fill(bit [7:0] pg, bit [7:0] fr);
      tlb_pg[fifo_slot] = pg;
      tlb_fr[fifo_slot] = fr;
      tlb_ok[fifo_slot] = 1'b1;
      fifo_slot = 4'((32'(fifo_slot) + 1) % TLB_N);
    endfunction

    // Predict the translation of one accepted address and queue it
    function void record_address(logic [VA_W-1:0] va);
      xlat_t    x;
      bit [7:0] pg;
      bit [7:0] fr;
      bit       found;
      pg    = 8'((32'(va) >> OFS_BITS) % PAGE_N);
      fr    = '0;
      found = 1'b0;
      x.fault    = 1'b0;
      x.no_frame = 1'b0;
      for (int i = 0; i < TLB_N; i++) begin
        if (!found && tlb_ok[i] && tlb_pg[i] == pg) begin
          found = 1'b1;
          fr    = tlb_fr[i];
        end
      end
      if (found) begin
        if (hit_cnt != CNT_MAX) hit_cnt++;
      end else if (pt_ok[pg]) begin
        fr = pt_frame[pg];
        tlb_fill(pg, fr);
      end else if (32'(free_frame) < FRAME_N) begin
        fr = free_frame[7:0];
        free_frame++;
        pt_frame[pg] = fr;
        pt_ok[pg]    = 1'b1;
        x.fault      = 1'b1;
        if (fault_cnt != CNT_MAX) fault_cnt++;
        tlb_fill(pg, fr);
      end else begin
        x.no_frame = 1'b1;
      end
      if (ref_cnt != CNT_MAX) ref_cnt++;
      x.page   = pg;
      x.offset = va[OFS_BITS-1:0];
      x.frame  = fr;
      x.paddr  = PA_W'((32'(fr) << OFS_BITS) | 32'(va[OFS_BITS-1:0]));
      x.hit    = found;
      x.refs   = ref_cnt;
      x.faults = fault_cnt;
      x.hits   = hit_cnt;
      pending_xlats.push_back(x);
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        fails++;
      end
    endfunction

    function void check_translation(xlat_t got);
      xlat_t e;
      if (pending_xlats.size() == 0) begin
        $error("result transfer with no translation pending");
        fails++;
        return;
      end
      e = pending_xlats.pop_front();
      cmp_field("page_number", 32'(e.page), 32'(got.page));
      cmp_field("page_offset", 32'(e.offset), 32'(got.offset));
      cmp_field("mapped_frame", 32'(e.frame), 32'(got.frame));
      cmp_field("physical_address", 32'(e.paddr), 32'(got.paddr));
      cmp_field("tlb_hit", 32'(e.hit), 32'(got.hit));
      cmp_field("page_fault", 32'(e.fault), 32'(got.fault));
      cmp_field("no_frame", 32'(e.no_frame), 32'(got.no_frame));
      cmp_field("reference_total", e.refs, got.refs);
      cmp_field("fault_total", e.faults, got.faults);
      cmp_field("hit_total", e.hits, got.hits);
    endfunction

    function int outstanding();
      return pending_xlats.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [VA_W-1:0]   virtual_address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PNUM_W-1:0] page_number_o;
  logic [OFF_W-1:0]  page_offset_o;
  logic [FNUM_W-1:0] mapped_frame_o;
  logic [PA_W-1:0]   physical_address_o;
  logic              tlb_hit_o;
  logic              page_fault_o;
  logic              no_frame_o;
  logic [CNT_W-1:0]  reference_total_o;
  logic [CNT_W-1:0]  fault_total_o;
  logic [CNT_W-1:0]  hit_total_o;

  xlat_board   board = new();
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  bit [7:0]    hot_pages[8];
  bit [7:0]    sweep_pg = '0;

  always #1 clk_i = ~clk_i;

  tlb_page_table_translator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .virtual_address_i  (virtual_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .page_number_o      (page_number_o),
    .page_offset_o      (page_offset_o),
    .mapped_frame_o     (mapped_frame_o),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .no_frame_o         (no_frame_o),
    .reference_total_o  (reference_total_o),
    .fault_total_o      (fault_total_o),
    .hit_total_o        (hit_total_o)
  );

  // Offer one address; return after the edge at which it transfers
  task automatic send_address(input logic [VA_W-1:0] va);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    virtual_address_i <= va;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.record_address(va);
    hot_pages[$urandom_range(0, 7)] = va[15:8];
  endtask

  function automatic logic [VA_W-1:0] pick_address();
    int unsigned mode;
    logic [7:0]  pg;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      pg = hot_pages[$urandom_range(0, 7)];
    end else if (mode < 8) begin
      pg = 8'($urandom);
    end else begin
      pg = sweep_pg;
      sweep_pg++;
    end
    return {pg, 8'($urandom)};
  endfunction

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // Result side back-pressure: short random bursts, or one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    xlat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.page     = page_number_o;
      got.offset   = page_offset_o;
      got.frame    = mapped_frame_o;
      got.paddr    = physical_address_o;
      got.hit      = tlb_hit_o;
      got.fault    = page_fault_o;
      got.no_frame = no_frame_o;
      got.refs     = reference_total_o;
      got.faults   = fault_total_o;
      got.hits     = hit_total_o;
      board.check_translation(got);
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) hot_pages[i] = 8'(i);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, repeats for TLB hits
    send_address(16'h0000);
    send_address(16'hFFFF);
    send_address(16'h00FF);
    send_address(16'hFF00);
    send_address(16'h0100);
    send_address(16'h5AA5);
    send_address(16'hA55A);
    send_address(16'h01FF);
    // twelve new pages: 17 distinct pages overflow the 16-entry TLB, page 0 gets evicted
    for (int p = 16; p < 28; p++) send_address({8'(p), 8'($urandom)});
    // page 0 now only in the page table, then hits again
    send_address(16'h0042);
    send_address(16'h0043);
    send_address(16'hFF80);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int n = 0; n < RAND_N; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 250) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      if (n == 400) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      send_address(pick_address());
    end
    // one more full sweep so every frame ends up allocated
    for (int p = 0; p < PAGE_N; p++) send_address({8'(p), 8'($urandom)});
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      $error("%0d translations never came out", board.outstanding());
      board.fails++;
    end
    if (board.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
